// ----- rtl/avs_pkg.sv -----
// shared constants, register codes and small helpers for the autoranging scaler
`default_nettype none
package avs_pkg;

	localparam int CODE_W     = 16;
	localparam int STEP_W     = 20;
	localparam int NV_W       = 32;
	localparam int LIM_W      = 31;
	localparam int CDIV_W     = 16;
	localparam int FLD_W      = 12;
	localparam int PACK_W     = 60;
	localparam int CFG_IDX_W  = 3;
	localparam int RANGE_W    = 3;
	localparam int SMP_W      = 8;
	localparam int WIDE_W     = NV_W + FLD_W;
	localparam int CNT_W      = 6;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_CODE_ZERO   = 3'd0,
		CFG_STEP_NV     = 3'd1,
		CFG_BIAS_NV     = 3'd2,
		CFG_OVER_LIMIT  = 3'd3,
		CFG_COMMON_DIV  = 3'd4,
		CFG_RANGE_MULTS = 3'd5,
		CFG_RANGE_DIVS  = 3'd6
	} cfg_idx_t;

	localparam logic [RANGE_W-1:0] TOP_RANGE = 3'd4;

	localparam logic [CODE_W-1:0] RST_CODE_ZERO  = 16'd32768;
	localparam logic [STEP_W-1:0] RST_STEP_NV    = 20'd35700;
	localparam logic [NV_W-1:0]   RST_BIAS_NV    = 32'd0;
	localparam logic [LIM_W-1:0]  RST_OVER_LIMIT = 31'd1000000000;
	localparam logic [CDIV_W-1:0] RST_COMMON_DIV = 16'd1000;
	localparam logic [PACK_W-1:0] RST_PACKED     = 60'd0;

	// mux address A1A0 for each divider range
	function automatic logic [1:0] mux_addr(input logic [RANGE_W-1:0] r);
		logic [1:0] a;
		case (r)
			3'd1:    a = 2'd3;
			3'd2:    a = 2'd2;
			3'd3:    a = 2'd1;
			default: a = 2'd0;
		endcase
		return a;
	endfunction

	// 12-bit field of a packed per-range register
	function automatic logic [FLD_W-1:0] range_field(input logic [PACK_W-1:0] pk,
			input logic [RANGE_W-1:0] r);
		logic [FLD_W-1:0] f;
		case (r)
			3'd1:    f = pk[2*FLD_W-1:FLD_W];
			3'd2:    f = pk[3*FLD_W-1:2*FLD_W];
			3'd3:    f = pk[4*FLD_W-1:3*FLD_W];
			3'd4:    f = pk[5*FLD_W-1:4*FLD_W];
			default: f = pk[FLD_W-1:0];
		endcase
		return f;
	endfunction

endpackage
`default_nettype wire

// ----- rtl/avs_in_if.sv -----
// converter code channel
`default_nettype none
interface avs_in_if import avs_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [CODE_W-1:0] adc_code;

	modport source (output valid, output adc_code, input ready);
	modport sink   (input valid, input adc_code, output ready);
endinterface
`default_nettype wire

// ----- rtl/avs_out_if.sv -----
// result channel: readings and range change requests
`default_nettype none
interface avs_out_if import avs_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic                     is_reading;
	logic [RANGE_W-1:0]       range_index;
	logic                     mux_enable;
	logic [1:0]               mux_address;
	logic signed [NV_W-1:0]   voltage_uv;
	logic                     clamped;

	modport source (output valid, output is_reading, output range_index, output mux_enable,
		output mux_address, output voltage_uv, output clamped, input ready);
	modport sink   (input valid, input is_reading, input range_index, input mux_enable,
		input mux_address, input voltage_uv, input clamped, output ready);
endinterface
`default_nettype wire

// ----- rtl/autorange_voltage_scaler.sv -----
// autoranging voltmeter scaler: averaging, bit-serial scaling and range control
// a code that does not close a group leaves the scaler idle, one word per cycle until a group's last code
// a group's last code: a serial nanovolt multiply and a check state, then either
//   a range change word, or a reading after a divide by the common divisor,
//   a 12-step range multiply and a 44-step range divide (a zero divisor skips its divide)
// one shared shift-add multiplier and one restoring divider, one bit per cycle
// arst_n clears control, range and group count; configuration registers return to their defaults
`default_nettype none
module autorange_voltage_scaler import avs_pkg::*; #(
	parameter int SAMPLES_PER_READING = 4
) (
	input  logic                 clk,
	input  logic                 arst_n,
	avs_in_if.sink               in_ch,
	avs_out_if.source            out_ch,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [PACK_W-1:0]    cfg_data
);

	localparam logic [SMP_W-1:0] SMP_TARGET = SMP_W'(SAMPLES_PER_READING);

	typedef enum logic [6:0] {
		ST_IDLE    = 7'b0000001,
		ST_MUL_NV  = 7'b0000010,
		ST_CHECK   = 7'b0000100,
		ST_DIV_COM = 7'b0001000,
		ST_MUL_RNG = 7'b0010000,
		ST_DIV_RNG = 7'b0100000,
		ST_DONE    = 7'b1000000
	} state_t;

	// configuration registers
	logic [CODE_W-1:0] code_zero_q;
	logic [STEP_W-1:0] step_nv_q;
	logic [NV_W-1:0]   bias_nv_q;
	logic [LIM_W-1:0]  over_limit_q;
	logic [CDIV_W-1:0] common_div_q;
	logic [PACK_W-1:0] mults_q;
	logic [PACK_W-1:0] divs_q;

	// control
	state_t             state_q;
	logic [SMP_W-1:0]   smp_cnt_q;
	logic [RANGE_W-1:0] rng_q;
	logic [CNT_W-1:0]   cnt_q;
	logic               out_valid_q;

	// datapath
	logic [CODE_W-1:0] avg_q;
	logic [WIDE_W-1:0] acc_q;
	logic [WIDE_W-1:0] mcand_q;
	logic [STEP_W-1:0] mpl_q;
	logic [WIDE_W-1:0] quo_q;
	logic [CDIV_W-1:0] rem_q;
	logic [CDIV_W-1:0] dvs_q;
	logic              sign_q;
	logic              clamp_q;
	logic              reading_q;

	// result word
	logic                   res_reading_q;
	logic [RANGE_W-1:0]     res_range_q;
	logic signed [NV_W-1:0] res_uv_q;
	logic                   res_clamp_q;

	logic              in_acc;
	logic [CODE_W:0]   avg_sum;
	logic [CODE_W-1:0] avg_next;
	logic [SMP_W-1:0]  smp_inc;
	logic              group_done;
	logic [CODE_W:0]   diff;
	logic [WIDE_W-1:0] acc_add;
	logic [CDIV_W:0]   trial;
	logic [CDIV_W:0]   trial_sub;
	logic              fits;
	logic [CDIV_W-1:0] rem_nxt;
	logic [WIDE_W-1:0] quo_nxt;
	logic [NV_W-1:0]   nv;
	logic [NV_W-1:0]   nv_mag;
	logic              over;
	logic              can_step;
	logic [NV_W-1:0]   mag_use;
	logic [FLD_W-1:0]  mult_sel;
	logic [FLD_W-1:0]  div_sel;
	logic [NV_W-1:0]   uv_final;
	logic              out_free;
	logic              last_step;

	assign in_acc = in_ch.valid & in_ch.ready;
	// one code at a time into the averager; a group's last code holds it until done
	assign in_ch.ready = (state_q == ST_IDLE);

	// running halving average, the first code of a group loads it
	assign avg_sum    = {1'b0, avg_q} + {1'b0, in_ch.adc_code};
	assign avg_next   = (smp_cnt_q == '0) ? in_ch.adc_code : avg_sum[CODE_W:1];
	assign smp_inc    = smp_cnt_q + SMP_W'(1);
	assign group_done = (smp_inc == SMP_TARGET);

	// signed offset from zero code, two's complement in 17 bits
	assign diff = {1'b0, avg_next} - {1'b0, code_zero_q};

	// shared shift-add step
	assign acc_add = mpl_q[0] ? acc_q + mcand_q : acc_q;

	// shared restoring divide step
	assign trial     = {rem_q, quo_q[WIDE_W-1]};
	assign fits      = (trial >= {1'b0, dvs_q});
	assign trial_sub = trial - {1'b0, dvs_q};
	assign rem_nxt   = fits ? trial_sub[CDIV_W-1:0] : trial[CDIV_W-1:0];
	assign quo_nxt   = {quo_q[WIDE_W-2:0], fits};

	assign last_step = (cnt_q == CNT_W'(1));

	// nanovolts wrap to 32 bits; magnitude of the most negative value fits unsigned
	assign nv       = acc_q[NV_W-1:0];
	assign nv_mag   = nv[NV_W-1] ? (~nv + NV_W'(1)) : nv;
	assign over     = (nv_mag > {1'b0, over_limit_q});
	assign can_step = (rng_q < TOP_RANGE);
	// top range overflow clamps to the limit, sign kept in sign_q
	assign mag_use  = over ? {1'b0, over_limit_q} : nv_mag;

	assign mult_sel = range_field(mults_q, rng_q);
	assign div_sel  = range_field(divs_q, rng_q);

	// saturate the final magnitude into signed 32 bits
	always_comb begin
		if (sign_q) begin
			if (quo_q[WIDE_W-1:NV_W] != '0 || (quo_q[NV_W-1] && quo_q[NV_W-2:0] != '0))
				uv_final = {1'b1, {(NV_W-1){1'b0}}};
			else
				uv_final = ~quo_q[NV_W-1:0] + NV_W'(1);
		end else begin
			if (quo_q[WIDE_W-1:NV_W-1] != '0)
				uv_final = {1'b0, {(NV_W-1){1'b1}}};
			else
				uv_final = quo_q[NV_W-1:0];
		end
	end

	// output stage frees when empty or being taken
	assign out_free = !out_valid_q || out_ch.ready;

	// configuration port
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			code_zero_q  <= RST_CODE_ZERO;
			step_nv_q    <= RST_STEP_NV;
			bias_nv_q    <= RST_BIAS_NV;
			over_limit_q <= RST_OVER_LIMIT;
			common_div_q <= RST_COMMON_DIV;
			mults_q      <= RST_PACKED;
			divs_q       <= RST_PACKED;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_CODE_ZERO:   code_zero_q  <= cfg_data[CODE_W-1:0];
				CFG_STEP_NV:     step_nv_q    <= cfg_data[STEP_W-1:0];
				CFG_BIAS_NV:     bias_nv_q    <= cfg_data[NV_W-1:0];
				CFG_OVER_LIMIT:  over_limit_q <= cfg_data[LIM_W-1:0];
				CFG_COMMON_DIV:  common_div_q <= cfg_data[CDIV_W-1:0];
				CFG_RANGE_MULTS: mults_q      <= cfg_data;
				CFG_RANGE_DIVS:  divs_q       <= cfg_data;
				default: ;
			endcase
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			smp_cnt_q   <= '0;
			rng_q       <= '0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// the finished word loads as the previous one leaves
			if (state_q == ST_DONE && out_free)
				out_valid_q <= 1'b1;
			else if (out_ch.ready)
				out_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						if (group_done) begin
							smp_cnt_q <= '0;
							cnt_q     <= CNT_W'(STEP_W);
							state_q   <= ST_MUL_NV;
						end else begin
							smp_cnt_q <= smp_inc;
						end
					end
				end
				ST_MUL_NV: begin
					cnt_q <= cnt_q - CNT_W'(1);
					if (last_step)
						state_q <= ST_CHECK;
				end
				ST_CHECK: begin
					if (over && can_step) begin
						rng_q   <= rng_q + RANGE_W'(1);
						state_q <= ST_DONE;
					end else if (common_div_q == '0) begin
						// zero divisor gives a zero quotient, skip the divide
						cnt_q   <= CNT_W'(FLD_W);
						state_q <= ST_MUL_RNG;
					end else begin
						cnt_q   <= CNT_W'(NV_W);
						state_q <= ST_DIV_COM;
					end
				end
				ST_DIV_COM: begin
					if (last_step) begin
						cnt_q   <= CNT_W'(FLD_W);
						state_q <= ST_MUL_RNG;
					end else begin
						cnt_q <= cnt_q - CNT_W'(1);
					end
				end
				ST_MUL_RNG: begin
					if (last_step) begin
						if (div_sel == '0) begin
							state_q <= ST_DONE;
						end else begin
							cnt_q   <= CNT_W'(WIDE_W);
							state_q <= ST_DIV_RNG;
						end
					end else begin
						cnt_q <= cnt_q - CNT_W'(1);
					end
				end
				ST_DIV_RNG: begin
					cnt_q <= cnt_q - CNT_W'(1);
					if (last_step)
						state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (out_free) begin
						// a reading sends the next group back to the lowest range
						if (reading_q)
							rng_q <= '0;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					avg_q <= avg_next;
					// accumulator starts at the bias, so the serial sum adds it for free
					acc_q   <= {{(WIDE_W-NV_W){1'b0}}, bias_nv_q};
					mcand_q <= {{(WIDE_W-CODE_W-1){diff[CODE_W]}}, diff};
					mpl_q   <= step_nv_q;
				end
			end
			ST_MUL_NV: begin
				acc_q   <= acc_add;
				mcand_q <= mcand_q << 1;
				mpl_q   <= mpl_q >> 1;
			end
			ST_CHECK: begin
				sign_q    <= nv[NV_W-1];
				clamp_q   <= over && !can_step;
				reading_q <= !(over && can_step);
				acc_q     <= '0;
				mcand_q   <= '0;
				mpl_q     <= STEP_W'(mult_sel);
				quo_q     <= {mag_use, {FLD_W{1'b0}}};
				rem_q     <= '0;
				dvs_q     <= common_div_q;
			end
			ST_DIV_COM: begin
				quo_q <= quo_nxt;
				rem_q <= rem_nxt;
				if (last_step)
					mcand_q <= {{FLD_W{1'b0}}, quo_nxt[NV_W-1:0]};
			end
			ST_MUL_RNG: begin
				acc_q   <= acc_add;
				mcand_q <= mcand_q << 1;
				mpl_q   <= mpl_q >> 1;
				if (last_step) begin
					quo_q <= (div_sel == '0) ? '0 : acc_add;
					rem_q <= '0;
					dvs_q <= CDIV_W'(div_sel);
				end
			end
			ST_DIV_RNG: begin
				quo_q <= quo_nxt;
				rem_q <= rem_nxt;
			end
			ST_DONE: begin
				if (out_free) begin
					res_reading_q <= reading_q;
					res_range_q   <= rng_q;
					res_uv_q      <= reading_q ? $signed(uv_final) : '0;
					res_clamp_q   <= clamp_q;
				end
			end
			default: ;
		endcase
	end

	assign out_ch.valid       = out_valid_q;
	assign out_ch.is_reading  = res_reading_q;
	assign out_ch.range_index = res_range_q;
	assign out_ch.mux_enable  = (res_range_q != '0);
	assign out_ch.mux_address = mux_addr(res_range_q);
	assign out_ch.voltage_uv  = res_uv_q;
	assign out_ch.clamped     = res_clamp_q;

endmodule
`default_nettype wire

// ----- rtl/avs_checker.sv -----
// port-level checks on the scaler's result channel, bound to the top level
`default_nettype none
module avs_checker import avs_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	avs_out_if.source out_ch
);

	// a stalled word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.voltage_uv)
		&& $stable(out_ch.range_index) && $stable(out_ch.is_reading))
		else $error("result word changed while stalled");

	// a range change word names a range above the lowest and carries no reading or clamp
	a_change_word: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && !out_ch.is_reading |-> out_ch.range_index != '0
		&& out_ch.voltage_uv == '0 && !out_ch.clamped)
		else $error("malformed range change word");

	// mux enable follows the range, and the range stays within the top range
	a_mux_enable: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid |-> (out_ch.mux_enable == (out_ch.range_index != '0))
		&& out_ch.range_index <= TOP_RANGE)
		else $error("mux enable does not match range");

	// clamping only happens on a reading in the top range
	a_clamp_top: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && out_ch.clamped |-> out_ch.is_reading
		&& out_ch.range_index == TOP_RANGE)
		else $error("clamp outside the top range");

endmodule

bind autorange_voltage_scaler avs_checker u_avs_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.out_ch (out_ch)
);
`default_nettype wire
